// ===== src/mlf_pkg.sv =====
// Package for the MAC learning forwarder: action codes, widths and the
// request record that travels along the row of table cells. No dependencies.
package mlf_pkg;

  localparam int unsigned PortW       = 8;
  localparam int unsigned AddrW       = 48;
  localparam int unsigned McastBit    = 40;
  localparam int unsigned TableDepthD = 128;

  typedef enum logic [1:0] {
    ACT_FORWARD = 2'd0,
    ACT_FLOOD   = 2'd1,
    ACT_DROP    = 2'd2
  } act_e;

  typedef struct packed {
    logic [PortW-1:0] in_port;
    logic [AddrW-1:0] dest_addr;
    logic [AddrW-1:0] src_addr;
    logic             learned;
    logic             found;
    logic [PortW-1:0] found_port;
  } mlf_req_t;

endpackage

// ===== src/mlf_cell.sv =====
// One table entry of the MAC learning forwarder with its request stage.
// Learns or refreshes the source and resolves the destination. Uses mlf_pkg.
module mlf_cell import mlf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     req_valid_i,
  input  mlf_req_t req_i,
  output logic     req_valid_o,
  output mlf_req_t req_o
);

  logic             ent_valid_q, ent_valid_d;
  logic [AddrW-1:0] ent_addr_q, ent_addr_d;
  logic [PortW-1:0] ent_port_q, ent_port_d;
  logic             req_valid_q;
  mlf_req_t         req_q, req_d;

  logic src_mcast, src_hit, do_learn, dst_hit, upd;

  always_comb begin
    src_mcast = req_i.src_addr[McastBit];
    src_hit   = ent_valid_q && (ent_addr_q == req_i.src_addr) && !src_mcast;
    do_learn  = !ent_valid_q && !req_i.learned && !src_mcast;
    upd       = req_valid_i && en_i;

    ent_valid_d = ent_valid_q || do_learn;
    ent_addr_d  = do_learn ? req_i.src_addr : ent_addr_q;
    ent_port_d  = (src_hit || do_learn) ? req_i.in_port : ent_port_q;

    dst_hit = ent_valid_d && (ent_addr_d == req_i.dest_addr);

    req_d            = req_i;
    req_d.learned    = req_i.learned || src_hit || do_learn;
    req_d.found      = req_i.found || dst_hit;
    req_d.found_port = dst_hit ? ent_port_d : req_i.found_port;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
      req_valid_q <= 1'b0;
    end else if (en_i) begin
      req_valid_q <= req_valid_i;
      if (upd) begin
        ent_valid_q <= ent_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      ent_addr_q <= ent_addr_d;
      ent_port_q <= ent_port_d;
    end
    if (en_i) begin
      req_q <= req_d;
    end
  end

  assign req_valid_o = req_valid_q;
  assign req_o       = req_q;

endmodule

// ===== src/mac_learning_forwarder.sv =====
// MAC learning forwarder top level: a row of TABLE_DEPTH table cells and the
// output register. Uses mlf_pkg and mlf_cell.
//
// Usage:
//   A request (in_port_i, dest_addr_i, src_addr_i) is taken when in_valid_i is
//   high and in_stall_o is low. Each request walks the row of cells, one cell
//   a cycle unless the row is held; each cell holds one table entry, learns
//   or refreshes the source and checks the destination. Entries fill in order
//   and are never evicted. The result (action_o, out_port_o, learn_failed_o)
//   is shown with out_valid_o and taken when out_stall_i is low.
//   Each request passes the TABLE_DEPTH cell registers and the output register.
//   Throughput: one request per cycle unless the row is held; requests
//   follow each other down the row, so each sees the table as left by the
//   one before it. When the receiver stalls with a result waiting, the whole
//   row holds and in_stall_o is raised in the same cycle.
//   Reset clears every entry's valid mark and empties the row; no clearing
//   pass is needed, requests are taken from the first cycle after reset.
module mac_learning_forwarder import mlf_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthD
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [PortW-1:0] in_port_i,
  input  logic [AddrW-1:0] dest_addr_i,
  input  logic [AddrW-1:0] src_addr_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       action_o,
  output logic [PortW-1:0] out_port_o,
  output logic             learn_failed_o
);

  logic     adv;
  logic     stg_valid [TABLE_DEPTH+1];
  mlf_req_t stg_req   [TABLE_DEPTH+1];

  logic             out_valid_q;
  act_e             action_q, action_d;
  logic [PortW-1:0] out_port_q, out_port_d;
  logic             learn_failed_q, learn_failed_d;

  mlf_req_t last;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  assign stg_valid[0]          = in_valid_i;
  assign stg_req[0].in_port    = in_port_i;
  assign stg_req[0].dest_addr  = dest_addr_i;
  assign stg_req[0].src_addr   = src_addr_i;
  assign stg_req[0].learned    = 1'b0;
  assign stg_req[0].found      = 1'b0;
  assign stg_req[0].found_port = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    mlf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (adv),
      .req_valid_i (stg_valid[i]),
      .req_i       (stg_req[i]),
      .req_valid_o (stg_valid[i+1]),
      .req_o       (stg_req[i+1])
    );
  end

  assign last = stg_req[TABLE_DEPTH];

  always_comb begin
    out_port_d     = '0;
    learn_failed_d = 1'b0;
    if (last.src_addr[McastBit]) begin
      action_d = ACT_DROP;
    end else begin
      learn_failed_d = !last.learned;
      if (last.dest_addr[McastBit] || !last.found) begin
        action_d = ACT_FLOOD;
      end else if (last.found_port == last.in_port) begin
        action_d = ACT_DROP;
      end else begin
        action_d   = ACT_FORWARD;
        out_port_d = last.found_port;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= stg_valid[TABLE_DEPTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      action_q       <= action_d;
      out_port_q     <= out_port_d;
      learn_failed_q <= learn_failed_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = action_q;
  assign out_port_o     = out_port_q;
  assign learn_failed_o = learn_failed_q;

endmodule

// ===== bench/mac_learning_forwarder_tb.sv =====
// Testbench for mac_learning_forwarder: directed, random, table-full and
// back-pressure requests, checked against a bridge table predictor.
// Depends on mlf_pkg and the mac_learning_forwarder RTL.
`timescale 1ns / 100ps

module mac_learning_forwarder_tb;
  import mlf_pkg::*;

  localparam int unsigned DEPTH       = TableDepthD;
  localparam int unsigned POOL_N      = 40;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    act_e             action;
    logic [PortW-1:0] port;
    logic             failed;
  } verdict_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic [PortW-1:0] in_port_i      = '0;
  logic [AddrW-1:0] dest_addr_i    = '0;
  logic [AddrW-1:0] src_addr_i     = '0;
  logic             out_stall_i    = 1'b1;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [1:0]       action_o;
  logic [PortW-1:0] out_port_o;
  logic             learn_failed_o;

  // predictor copy of the bridge table
  logic             fdb_valid [DEPTH];
  logic [AddrW-1:0] fdb_addr  [DEPTH];
  logic [PortW-1:0] fdb_port  [DEPTH];
  int unsigned      fdb_fill;

  logic [AddrW-1:0] mac_pool [POOL_N];
  verdict_t         verdict_q [$];
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      hold_left      = 0;
  int unsigned      cycle_cnt      = 0;
  int unsigned      err_cnt        = 0;

  mac_learning_forwarder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_port_i     (in_port_i),
    .dest_addr_i   (dest_addr_i),
    .src_addr_i    (src_addr_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .action_o      (action_o),
    .out_port_o    (out_port_o),
    .learn_failed_o(learn_failed_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int lookup_station(logic [AddrW-1:0] addr);
    for (int i = 0; i < DEPTH; i++) begin
      if (fdb_valid[i] && fdb_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  function automatic verdict_t decide_frame(logic [PortW-1:0] port,
                                            logic [AddrW-1:0] dst,
                                            logic [AddrW-1:0] src);
    verdict_t v;
    int       hit;
    v = '{ACT_FLOOD, '0, 1'b0};
    if (src[McastBit]) begin
      v.action = ACT_DROP;
      return v;
    end
    hit = lookup_station(src);
    if (hit >= 0) begin
      fdb_port[hit] = port;
    end else if (fdb_fill < DEPTH) begin
      fdb_valid[fdb_fill] = 1'b1;
      fdb_addr[fdb_fill]  = src;
      fdb_port[fdb_fill]  = port;
      fdb_fill++;
    end else begin
      v.failed = 1'b1;
    end
    if (!dst[McastBit]) begin
      hit = lookup_station(dst);
      if (hit >= 0) begin
        if (fdb_port[hit] == port) begin
          v.action = ACT_DROP;
        end else begin
          v.action = ACT_FORWARD;
          v.port   = fdb_port[hit];
        end
      end
    end
    return v;
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[AddrW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] unicast_addr();
    logic [AddrW-1:0] a;
    a = rand_addr();
    a[McastBit] = 1'b0;
    return a;
  endfunction

  function automatic logic [AddrW-1:0] multicast_addr();
    logic [AddrW-1:0] a;
    a = rand_addr();
    a[McastBit] = 1'b1;
    return a;
  endfunction

  // result checker and receiver stall
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result: action %0d out_port %0d learn_failed %0b",
               action_o, out_port_o, learn_failed_o);
        err_cnt++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (action_o !== exp_v.action) begin
          $error("action: expected %0d, got %0d", exp_v.action, action_o);
          err_cnt++;
        end
        if (out_port_o !== exp_v.port) begin
          $error("out_port: expected %0d, got %0d", exp_v.port, out_port_o);
          err_cnt++;
        end
        if (learn_failed_o !== exp_v.failed) begin
          $error("learn_failed: expected %0b, got %0b", exp_v.failed, learn_failed_o);
          err_cnt++;
        end
      end
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic offer_frame(logic [PortW-1:0] port, logic [AddrW-1:0] dst,
                             logic [AddrW-1:0] src);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_port_i   <= port;
    dest_addr_i <= dst;
    src_addr_i  <= src;
    do @(posedge clk_i); while (in_stall_o);
    verdict_q.push_back(decide_frame(port, dst, src));
  endtask

  task automatic random_frame();
    logic [PortW-1:0] port;
    logic [AddrW-1:0] src;
    logic [AddrW-1:0] dst;
    int unsigned      sel;
    port = ($urandom_range(3) == 0) ? PortW'($urandom_range(255)) : PortW'($urandom_range(7));
    sel  = $urandom_range(99);
    if (sel < 80)      src = mac_pool[$urandom_range(POOL_N-1)];
    else if (sel < 86) src = multicast_addr();
    else if (sel < 93) src = unicast_addr();
    else               src = rand_addr();
    sel = $urandom_range(99);
    if (sel < 65)      dst = mac_pool[$urandom_range(POOL_N-1)];
    else if (sel < 72) dst = src;
    else if (sel < 82) dst = multicast_addr();
    else               dst = rand_addr();
    offer_frame(port, dst, src);
  endtask

  task automatic test_directed();
    offer_frame(8'd4, 48'h0000_0000_0001, 48'hFFFF_FFFF_FFFF);
    offer_frame(8'd0, 48'h0100_0000_0000, 48'h0100_0000_0000);
    offer_frame(8'd255, 48'h0000_0000_0000, 48'h0000_0000_0000);
    offer_frame(8'd0, 48'h0000_0000_0000, 48'hFEFF_FFFF_FFFF);
    offer_frame(8'd255, 48'hFEFF_FFFF_FFFF, 48'h0000_0000_0000);
    offer_frame(8'd1, 48'hFEFF_FFFF_FFFE, 48'h0000_0000_0010);
    offer_frame(8'd3, 48'h0100_0000_0002, 48'h0000_0000_0A0A);
    offer_frame(8'd5, 48'h0000_0000_0010, 48'h0000_0000_0A0A);
    offer_frame(8'd9, 48'h0000_0000_0A0A, 48'h0000_0000_0B0B);
    offer_frame(8'd5, 48'h0000_0000_0A0A, 48'h0000_0000_0C0C);
    offer_frame(8'd7, 48'h0000_0000_0D0D, 48'h0000_0000_0D0D);
    offer_frame(8'd1, 48'h0000_0000_0D0D, 48'h0000_0000_0010);
    offer_frame(8'd7, 48'h0000_0000_0B0B, 48'h0100_0000_0B0B);
    offer_frame(8'hAA, 48'h5555_5555_5555 & ~(48'd1 << McastBit), 48'hAAAA_AAAA_AAAA);
    offer_frame(8'h55, 48'hAAAA_AAAA_AAAA, 48'h5455_5555_5555);
    offer_frame(8'h10, 48'h5455_5555_5555, 48'h0000_0000_0B0B);
  endtask

  task automatic test_random_traffic(int unsigned n);
    repeat (n) random_frame();
  endtask

  task automatic test_table_full();
    logic [AddrW-1:0] fresh;
    offer_frame(8'd2, mac_pool[1], mac_pool[0]);
    while (fdb_fill < DEPTH) begin
      offer_frame(PortW'($urandom_range(255)), rand_addr(), unicast_addr());
    end
    fresh = unicast_addr();
    offer_frame(8'd6, mac_pool[0], fresh);
    offer_frame(8'd6, fresh, fresh);
    offer_frame(8'd12, mac_pool[1], mac_pool[0]);
    offer_frame(8'd13, mac_pool[0], mac_pool[1]);
    offer_frame(8'd12, mac_pool[0], mac_pool[2]);
    offer_frame(8'd3, mac_pool[0], multicast_addr());
    offer_frame(8'd3, multicast_addr(), unicast_addr());
  endtask

  task automatic test_backpressure();
    hold_left <= HOLD_CYCLES;
    repeat (200) random_frame();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      fdb_valid[i] = 1'b0;
      fdb_addr[i]  = '0;
      fdb_port[i]  = '0;
    end
    fdb_fill = 0;
    for (int i = 0; i < POOL_N; i++) mac_pool[i] = unicast_addr();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0, 0);
    test_directed();
    set_idling(17, 76);
    test_random_traffic(330);
    set_idling(76, 17);
    test_random_traffic(330);
    set_idling(0, 0);
    test_table_full();
    test_random_traffic(150);
    test_backpressure();

    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 16) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mlf_pkg.sv
src/mlf_cell.sv
src/mac_learning_forwarder.sv
bench/mac_learning_forwarder_tb.sv
